// File: hdl/slbck_pkg.sv
// shared types, constants and helpers for the sprite line blitter
package slbck_pkg;

   localparam int MAX_LINE_PIXELS_DEF = 512;
   localparam int QUEUE_DEPTH         = 4;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 10;

   localparam logic [5:0] KEY_COLOR_RESET   = 6'd12;
   localparam logic [9:0] LINE_PIXELS_RESET = 10'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PIXEL_PHASE = 3'd0,
      REG_KEYED_MODE  = 3'd1,
      REG_KEY_COLOR   = 3'd2,
      REG_LINE_PIXELS = 3'd3,
      REG_SKIP_FIRST  = 3'd4
   } csr_index_type;

   // byte lane that holds each logical pixel position
   typedef logic [1:0] lane_type;
   localparam lane_type LANE_OF_POS [4] = '{2'd2, 2'd3, 2'd0, 2'd1};

   // one queue entry, from one accepted source word, turns into one or two destination words
   typedef struct packed {
      logic [31:0] data0;
      logic [3:0]  en0;
      logic [31:0] data1;
      logic [3:0]  en1;
      logic        two;
      logic        last;
   } entry_type;

   function automatic logic [7:0] get_pixel(input logic [31:0] word, input logic [1:0] pos);
      logic [7:0] px;
      case (LANE_OF_POS[pos])
         2'd0:    px = word[7:0];
         2'd1:    px = word[15:8];
         2'd2:    px = word[23:16];
         default: px = word[31:24];
      endcase
      return px;
   endfunction

endpackage

// File: hdl/sprite_line_blitter_color_key_top.sv
// top level of the sprite line blitter with color key
// Takes one 32-bit source word per clock (four 8-bit pixels, pixels 0..3 in
// bytes 2,3,0,1), splices it with the previous word to shift the line by the
// destination pixel phase, and returns destination words with byte enables;
// in keyed mode pixels whose low six bits match the key are not written.
// A source word is taken every cycle while the four-entry result queue has
// room; each word gives zero or one result, and the last word of a line up to
// two, so the output port issues one result per cycle while rsp_tready is high.
// Each result passes through a queue slot and the output register. The user
// must write registers through the csr port between lines; the block does not enforce it.
module sprite_line_blitter_color_key_top import slbck_pkg::*; #(
   parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [31:0] src_word
   input  logic                   req_tlast,   // line_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // [31:0] write_data, [35:32] byte_enable
   output logic                   rsp_tlast,   // line_done
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic        q_full;
   logic        q_push;
   entry_type   q_entry;
   entry_type   q_head;
   logic        q_empty;
   logic        q_pop;
   logic [31:0] write_data;
   logic [3:0]  byte_enable;

   slbck_front #(
      .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .src_word   (req_tdata),
      .line_end   (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   slbck_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   slbck_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .empty       (q_empty),
      .pop         (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .write_data  (write_data),
      .byte_enable (byte_enable),
      .line_done   (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, byte_enable, write_data};

endmodule

// File: hdl/slbck_front.sv
// front end: config registers, line state and per-word lane splice with color key
module slbck_front import slbck_pkg::*; #(
   parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            src_word,
   input  logic                   line_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   q_full,
   output logic                   q_push,
   output entry_type              q_entry
);

   localparam int LW = $clog2(MAX_LINE_PIXELS + 1);

   logic [1:0]    phase_ff, phase_in;
   logic          keyed_ff, keyed_in;
   logic [5:0]    key_ff, key_in;
   logic [9:0]    line_pixels_ff, line_pixels_in;
   logic          skip_ff, skip_in;

   logic [31:0]   prev_ff, prev_in;
   logic [LW-1:0] left_ff, left_in;
   logic          started_ff, started_in;

   logic          accept;
   logic [7:0]    win_px [8];
   logic [LW-1:0] left0, left1, left2;
   logic          skip_eff;
   logic          main_en;
   logic [2:0]    main_base;
   logic [1:0]    main_qlo;
   logic [2:0]    used0, used1;
   logic [31:0]   main_data, flush_data;
   logic [3:0]    main_en_bits, flush_en_bits;
   logic          vis0_any, vis1_any;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;

   // configuration
   always_comb begin
      phase_in       = phase_ff;
      keyed_in       = keyed_ff;
      key_in         = key_ff;
      line_pixels_in = line_pixels_ff;
      skip_in        = skip_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_PIXEL_PHASE: phase_in       = csr_data[1:0];
            REG_KEYED_MODE:  keyed_in       = csr_data[0];
            REG_KEY_COLOR:   key_in         = csr_data[5:0];
            REG_LINE_PIXELS: line_pixels_in = csr_data[9:0];
            REG_SKIP_FIRST:  skip_in        = csr_data[0];
            default: ;
         endcase
      end
   end

   // pixel window: previous word then current word
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         win_px[i]     = get_pixel(prev_ff, 2'(i));
         win_px[i + 4] = get_pixel(src_word, 2'(i));
      end
   end

   always_comb begin
      if (started_ff) begin
         left0 = left_ff;
      end else if ({22'd0, line_pixels_ff} > 32'(MAX_LINE_PIXELS)) begin
         left0 = LW'(MAX_LINE_PIXELS);
      end else begin
         left0 = LW'(line_pixels_ff);
      end
      skip_eff  = skip_ff && (phase_ff != 2'd0);
      main_en   = started_ff || !skip_eff;
      main_base = (!started_ff && phase_ff == 2'd0) ? 3'd4 : 3'(3'd4 - {1'b0, phase_ff});
      main_qlo  = started_ff ? 2'd0 : phase_ff;
   end

   // destination word built from the spliced window
   always_comb begin
      logic       vis;
      logic       keep;
      logic [7:0] px;
      logic [2:0] rank;
      used0        = 3'd0;
      main_data    = 32'd0;
      main_en_bits = 4'd0;
      for (int q = 0; q < 4; q++) begin
         rank = 3'(q) - {1'b0, main_qlo};
         vis  = main_en && (2'(q) >= main_qlo) && (LW'(rank) < left0);
         px   = win_px[3'(main_base + 3'(q))];
         keep = !(keyed_ff && px[5:0] == key_ff);
         if (vis) begin
            used0 = used0 + 3'd1;
            if (keep) begin
               main_data[8*LANE_OF_POS[q] +: 8] = px;
               main_en_bits[LANE_OF_POS[q]]     = 1'b1;
            end
         end
      end
      vis0_any = (used0 != 3'd0);
      left1    = left0 - LW'(used0);
   end

   // flush word: tail pixels of the current word on line end
   always_comb begin
      logic       vis;
      logic       keep;
      logic [7:0] px;
      used1         = 3'd0;
      flush_data    = 32'd0;
      flush_en_bits = 4'd0;
      for (int q = 0; q < 4; q++) begin
         vis  = line_end && (phase_ff != 2'd0) && (2'(q) < phase_ff) && (LW'(q) < left1);
         px   = win_px[{1'b1, 2'(2'(q) - phase_ff)}];
         keep = !(keyed_ff && px[5:0] == key_ff);
         if (vis) begin
            used1 = used1 + 3'd1;
            if (keep) begin
               flush_data[8*LANE_OF_POS[q] +: 8] = px;
               flush_en_bits[LANE_OF_POS[q]]     = 1'b1;
            end
         end
      end
      vis1_any = (used1 != 3'd0);
      left2    = left1 - LW'(used1);
   end

   always_comb begin
      q_entry.data0 = vis0_any ? main_data : flush_data;
      q_entry.en0   = vis0_any ? main_en_bits : flush_en_bits;
      q_entry.data1 = flush_data;
      q_entry.en1   = flush_en_bits;
      q_entry.two   = vis0_any && vis1_any;
      q_entry.last  = line_end;
      // an end word with no pixels still yields one empty terminal result
      q_push        = accept && (vis0_any || vis1_any || line_end);
   end

   always_comb begin
      prev_in    = prev_ff;
      left_in    = left_ff;
      started_in = started_ff;
      if (accept) begin
         prev_in    = src_word;
         left_in    = left2;
         started_in = !line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 2'd0;
         keyed_ff       <= 1'b0;
         key_ff         <= KEY_COLOR_RESET;
         line_pixels_ff <= LINE_PIXELS_RESET;
         skip_ff        <= 1'b0;
         prev_ff        <= 32'd0;
         left_ff        <= '0;
         started_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         keyed_ff       <= keyed_in;
         key_ff         <= key_in;
         line_pixels_ff <= line_pixels_in;
         skip_ff        <= skip_in;
         prev_ff        <= prev_in;
         left_ff        <= left_in;
         started_ff     <= started_in;
      end
   end

endmodule

// File: hdl/slbck_queue.sv
// short queue of result entries between front and back
module slbck_queue import slbck_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type     slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("queue count did not follow push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree on empty");
`endif

endmodule

// File: hdl/slbck_back.sv
// back end: unpacks queue entries into single result transactions
module slbck_back import slbck_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] write_data,
   output logic [3:0]  byte_enable,
   output logic        line_done
);

   logic        valid_ff, valid_in;
   logic        half_ff, half_in;
   logic [31:0] data_ff, data_in;
   logic [3:0]  be_ff, be_in;
   logic        done_ff, done_in;
   logic        load;

   assign load = !empty && (!valid_ff || rsp_tready);
   assign pop  = load && (!head.two || half_ff);

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      data_in  = data_ff;
      be_in    = be_ff;
      done_in  = done_ff;
      if (load) begin
         valid_in = 1'b1;
         if (head.two && !half_ff) begin
            data_in = head.data0;
            be_in   = head.en0;
            done_in = 1'b0;
            half_in = 1'b1;
         end else begin
            data_in = half_ff ? head.data1 : head.data0;
            be_in   = half_ff ? head.en1 : head.en0;
            done_in = head.last;
            half_in = 1'b0;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      be_ff   <= be_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign write_data  = data_ff;
   assign byte_enable = be_ff;
   assign line_done   = done_ff;

`ifndef NO_ASSERTIONS
   a_half_needs_pair: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (!empty && head.two))
      else $error("second half pending without a paired entry");
   a_first_half_not_done: assert property (@(posedge clock) disable iff (reset)
      $rose(half_ff) |-> !done_ff)
      else $error("first word of a pair flagged as line end");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |=> $stable(data_ff) && $stable(done_ff))
      else $error("result changed while stalled");
`endif

endmodule

// File: verif/testbench.sv
// self-checking testbench for the sprite line blitter with color key
module testbench import slbck_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CAP     = 512;
   localparam int SETTLE       = 4;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_OFF_LEN = 300;
   localparam int REPORT_MAX   = 25;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [31:0] data;
      logic [3:0]  en;
      logic        done;
   } dest_word_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;   // [31:0] src_word
   logic                   req_tlast  = 1'b0; // line_end
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [39:0]            rsp_tdata;         // [31:0] write_data, [35:32] byte_enable
   logic                   rsp_tlast;         // line_done
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // predictor copy of the registers and line state
   logic [1:0]  cfg_phase;
   logic        cfg_keyed;
   logic [5:0]  cfg_key;
   logic [9:0]  cfg_pixels;
   logic        cfg_skip;
   logic [31:0] prior_word;
   int unsigned pixels_left;
   bit          in_line;

   dest_word_type dest_words_due[$];

   int mismatches     = 0;
   int words_sent     = 0;
   int lines_sent     = 0;
   int words_checked  = 0;
   int reg_writes     = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;
   bit gaps_on        = 1'b0;
   bit stall_on       = 1'b0;
   int hold_request   = 0;
   int hold_left      = 0;
   int pattern_age    = 0;
   logic [15:0] stall_pattern = 16'hffff;

   sprite_line_blitter_color_key_top #(
      .MAX_LINE_PIXELS(LINE_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pixel q of a word sits in byte q xor 2
   function automatic logic [7:0] pixel_at(input logic [31:0] w, input int q);
      return w[8*(q^2) +: 8];
   endfunction

   function automatic logic [31:0] pack_pixels(input logic [7:0] p0, input logic [7:0] p1,
                                               input logic [7:0] p2, input logic [7:0] p3);
      return {p1, p0, p3, p2};
   endfunction

   function automatic bit blit_block(input logic [7:0] win [8], input int base,
                                     input int qlo, input int qhi, output dest_word_type dw);
      logic [7:0] px;
      bit         vis;
      int         lane;
      dw  = '0;
      vis = 1'b0;
      for (int q = qlo; q < qhi && pixels_left != 0; q++) begin
         px   = win[(base + q) & 7];
         lane = q ^ 2;
         pixels_left--;
         vis = 1'b1;
         if (!(cfg_keyed && px[5:0] == cfg_key)) begin
            dw.data[8*lane +: 8] = px;
            dw.en[lane]          = 1'b1;
         end
      end
      return vis;
   endfunction

   function automatic void blit_source_word(input logic [31:0] w, input logic line_end);
      logic [7:0]    win [8];
      logic [7:0]    tail [8];
      dest_word_type produced[$];
      dest_word_type dw;
      int            p;
      bit            skip;
      p    = int'(cfg_phase);
      skip = cfg_skip && p != 0;
      if (!in_line)
         pixels_left = (int'(cfg_pixels) > LINE_CAP) ? LINE_CAP : int'(cfg_pixels);
      for (int q = 0; q < 4; q++) begin
         win[q]      = pixel_at(prior_word, q);
         win[q + 4]  = pixel_at(w, q);
         tail[q]     = pixel_at(w, q);
         tail[q + 4] = 8'h00;
      end
      if (!in_line) begin
         if (p == 0) begin
            if (blit_block(win, 4, 0, 4, dw)) produced.push_back(dw);
         end else if (!skip) begin
            if (blit_block(win, 4 - p, p, 4, dw)) produced.push_back(dw);
         end
      end else if (blit_block(win, 4 - p, 0, 4, dw)) begin
         produced.push_back(dw);
      end
      if (line_end) begin
         // flush the last p pixels into one more destination word
         if (p != 0 && blit_block(tail, 4 - p, 0, p, dw)) produced.push_back(dw);
         if (produced.size() == 0) produced.push_back('0);
         dw      = produced[produced.size() - 1];
         dw.done = 1'b1;
         produced[produced.size() - 1] = dw;
      end
      in_line    = !line_end;
      prior_word = w;
      foreach (produced[i]) dest_words_due.push_back(produced[i]);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      if (mismatches < REPORT_MAX)
         $display("%0t: result %0d %s: got %h, expected %h", $realtime, words_checked, what,
                  seen, wanted);
      mismatches++;
   endtask

   // lower valid and wait until every expected word is out and the pipe is quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (dest_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_PIXEL_PHASE: cfg_phase  = value[1:0];
         REG_KEYED_MODE:  cfg_keyed  = value[0];
         REG_KEY_COLOR:   cfg_key    = value[5:0];
         REG_LINE_PIXELS: cfg_pixels = value[9:0];
         REG_SKIP_FIRST:  cfg_skip   = value[0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic send_word(input logic [31:0] w, input logic line_end);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= line_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      blit_source_word(w, line_end);
      words_sent++;
      if (line_end) lines_sent++;
   endtask

   // random pixel, often carrying the key color in its low bits
   function automatic logic [7:0] random_pixel();
      logic [1:0] top;
      top = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) return {top, cfg_key};
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [31:0] random_word();
      return pack_pixels(random_pixel(), random_pixel(), random_pixel(), random_pixel());
   endfunction

   task automatic send_line(input int len);
      for (int i = 0; i < len; i++) send_word(random_word(), i == len - 1);
   endtask

   function automatic int words_for_line();
      int lp;
      int words;
      lp    = (int'(cfg_pixels) > LINE_CAP) ? LINE_CAP : int'(cfg_pixels);
      words = (lp + int'(cfg_phase) + 3) / 4;
      return (words > 0) ? words : 1;
   endfunction

   task automatic randomize_config();
      int pick;
      if ($urandom_range(0, 1)) write_reg(REG_PIXEL_PHASE, $urandom_range(0, 1023));
      if ($urandom_range(0, 1)) write_reg(REG_KEYED_MODE, $urandom_range(0, 1023));
      if ($urandom_range(0, 2) == 0) write_reg(REG_KEY_COLOR, $urandom_range(0, 1023));
      if ($urandom_range(0, 2) == 0) write_reg(REG_SKIP_FIRST, $urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 75)      write_reg(REG_LINE_PIXELS, $urandom_range(1, 24));
      else if (pick < 90) write_reg(REG_LINE_PIXELS, $urandom_range(25, 80));
      else if (pick < 97) write_reg(REG_LINE_PIXELS, $urandom_range(0, 3));
      else if (pick < 98) write_reg(REG_LINE_PIXELS, 513);
      else                write_reg(REG_LINE_PIXELS, $urandom_range(0, 1023));
   endtask

   task automatic test_reset_defaults();
      // one visible pixel, phase 0, no key
      send_word(32'ha1b2c3d4, 1'b1);
      send_word(32'hffffffff, 1'b1);
      send_word(32'h00000000, 1'b1);
      drain();
   endtask

   task automatic test_phases_and_flush();
      write_reg(REG_LINE_PIXELS, 8);
      write_reg(REG_PIXEL_PHASE, 3);
      // the end word only closes out the second word's pixels, no flush is left
      send_word(pack_pixels(8'h01, 8'h02, 8'h03, 8'h04), 1'b0);
      send_word(pack_pixels(8'h05, 8'h06, 8'h07, 8'h08), 1'b0);
      send_word(32'hffffffff, 1'b1);
      write_reg(REG_PIXEL_PHASE, 2);
      write_reg(REG_SKIP_FIRST, 1);
      write_reg(REG_LINE_PIXELS, 6);
      send_word(32'h11223344, 1'b0);
      send_word(32'h55667788, 1'b1);
      // left clipping has no effect at phase 0
      write_reg(REG_PIXEL_PHASE, 0);
      write_reg(REG_LINE_PIXELS, 4);
      send_word(32'h99aabbcc, 1'b1);
      write_reg(REG_SKIP_FIRST, 0);
      drain();
   endtask

   task automatic test_color_key();
      write_reg(REG_KEYED_MODE, 1);
      write_reg(REG_KEY_COLOR, 63);
      write_reg(REG_PIXEL_PHASE, 1);
      send_word(pack_pixels(8'hff, 8'h3f, 8'h7f, 8'h12), 1'b1);
      write_reg(REG_KEY_COLOR, 0);
      write_reg(REG_PIXEL_PHASE, 0);
      send_word(pack_pixels(8'h00, 8'h40, 8'hc0, 8'h01), 1'b1);
      write_reg(REG_KEYED_MODE, 0);
      drain();
   endtask

   task automatic test_zero_and_oversize();
      // nothing visible: the line end gives the empty terminal word
      write_reg(REG_LINE_PIXELS, 0);
      send_word(32'hdeadbeef, 1'b0);
      send_word(32'h0badf00d, 1'b1);
      write_reg(REG_LINE_PIXELS, 600);
      write_reg(REG_PIXEL_PHASE, 3);
      send_word(32'h12345678, 1'b0);
      send_word(32'h87654321, 1'b1);
      drain();
   endtask

   task automatic test_midline_config();
      write_reg(REG_UNUSED, 'h3ff);
      write_reg(REG_PIXEL_PHASE, 1);
      write_reg(REG_LINE_PIXELS, 12);
      send_word(32'hc0c1c2c3, 1'b0);
      // only the pixel count is latched at line start
      write_reg(REG_PIXEL_PHASE, 3);
      write_reg(REG_KEYED_MODE, 1);
      write_reg(REG_KEY_COLOR, 'h05);
      send_word(pack_pixels(8'h05, 8'h45, 8'h85, 8'hc5), 1'b0);
      send_word(32'h76543210, 1'b1);
      write_reg(REG_KEYED_MODE, 0);
      drain();
   endtask

   task automatic test_long_lines();
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      write_reg(REG_LINE_PIXELS, 1023);
      write_reg(REG_PIXEL_PHASE, $urandom_range(0, 3));
      send_line(words_for_line() + 1);
      write_reg(REG_LINE_PIXELS, 512);
      write_reg(REG_PIXEL_PHASE, 3);
      write_reg(REG_SKIP_FIRST, 1);
      send_line(words_for_line());
      write_reg(REG_SKIP_FIRST, 0);
      drain();
   endtask

   task automatic test_random_lines(input int budget);
      int stop_at;
      int lines_per_cfg;
      int len;
      int base;
      stop_at       = words_sent + budget;
      lines_per_cfg = 0;
      gaps_on       = 1'b1;
      stall_on      = 1'b1;
      while (words_sent < stop_at) begin
         if (lines_per_cfg == 0) begin
            randomize_config();
            lines_per_cfg = (cfg_pixels > 100) ? 1 : $urandom_range(1, 6);
         end
         lines_per_cfg--;
         base = words_for_line();
         case ($urandom_range(0, 9))
            0:       len = $urandom_range(1, 5);
            1:       len = base + $urandom_range(1, 3);
            2:       len = (base > 1) ? base - 1 : 1;
            default: len = base;
         endcase
         send_line(len);
      end
      drain();
   endtask

   task automatic test_backpressure();
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      write_reg(REG_PIXEL_PHASE, 2);
      write_reg(REG_LINE_PIXELS, 14);
      write_reg(REG_KEYED_MODE, 1);
      write_reg(REG_KEY_COLOR, $urandom_range(0, 63));
      hold_request = HOLD_OFF_LEN;
      for (int i = 0; i < 15; i++) send_line(4);
      drain();
   endtask

   task automatic test_steady_stream();
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      write_reg(REG_PIXEL_PHASE, 1);
      write_reg(REG_LINE_PIXELS, 9);
      write_reg(REG_KEYED_MODE, 0);
      for (int i = 0; i < 34; i++) send_line($urandom_range(1, 4));
      drain();
   endtask

   // receiver: rotating stall pattern, plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_on) begin
         pattern_age++;
         if (pattern_age == 64) begin
            pattern_age   = 0;
            stall_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
            if ($urandom_range(0, 3) == 0) stall_pattern = 16'hffff;
         end
         rsp_tready   <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      dest_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (dest_words_due.size() == 0) begin
            report_mismatch("arrived with nothing expected", rsp_tdata[31:0], 32'h0);
         end else begin
            want = dest_words_due.pop_front();
            if (rsp_tdata[31:0] !== want.data)
               report_mismatch("write_data", rsp_tdata[31:0], want.data);
            if (rsp_tdata[35:32] !== want.en)
               report_mismatch("byte_enable", 32'(rsp_tdata[35:32]), 32'(want.en));
            if (rsp_tlast !== want.done)
               report_mismatch("line_done", 32'(rsp_tlast), 32'(want.done));
         end
         words_checked++;
      end
   end

   // watchdog: any accepted transaction on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      cfg_phase   = 2'd0;
      cfg_keyed   = 1'b0;
      cfg_key     = KEY_COLOR_RESET;
      cfg_pixels  = LINE_PIXELS_RESET;
      cfg_skip    = 1'b0;
      prior_word  = '0;
      pixels_left = 0;
      in_line     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_phases_and_flush();
      test_color_key();
      test_zero_and_oversize();
      test_midline_config();
      test_long_lines();
      test_backpressure();
      test_steady_stream();
      test_random_lines(880);

      drain();
      repeat (8) @(posedge clock);
      $display("covered %0d source words in %0d lines with %0d register writes,",
               words_sent, lines_sent, reg_writes);
      $display("checked %0d destination words, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
